FILE: design/lgfr_pkg.sv
// lgfr_pkg: shared types, codes and constant tables of the LED gamma fade ramp.
// Used by the interfaces, the config registers, the fade core and the checker.
`timescale 1ns / 1ps

package lgfr_pkg;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 12;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FADE_STEP = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FADE_MULT = 4'd1;

    // Command codes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_OFF  = 2'd2;

    // Register reset values
    localparam logic [11:0] FADE_STEP_RST = 12'd64;
    localparam logic [4:0]  FADE_MULT_RST = 5'd2;

    // floor(x / 3) == (x * THIRD_RECIP) >> THIRD_SHIFT for any 8-bit x
    localparam logic [7:0] THIRD_RECIP = 8'd171;
    localparam int         THIRD_SHIFT = 9;

    // floor(n / m) == (n * recip_of(m)) >> RECIP_SHIFT for any 16-bit n
    localparam int RECIP_SHIFT = 21;

    typedef struct packed {
        logic [11:0] fade_step;
        logic [4:0]  mult;      // effective multiplier, never zero
        logic [21:0] recip;     // ceil(2^21 / mult)
        logic [15:0] sat_quot;  // floor(65535 / mult)
    } cfg_t;

    typedef struct packed {
        logic [7:0]  target;
        logic [15:0] accum;     // 8.8, duty in upper byte
        logic [15:0] step;
        logic        down;
        logic [7:0]  speedup;
        logic [7:0]  slowdown;
        logic        active;
    } fade_state_t;

    // Square-law brightness map: p*p*255/10000, 100 and above give full scale
    function automatic logic [7:0] sq_map(input logic [6:0] p);
        logic [7:0] v;
        case (p)
            7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6: v = 8'd0;
            7'd7, 7'd8:   v = 8'd1;
            7'd9, 7'd10:  v = 8'd2;
            7'd11, 7'd12: v = 8'd3;
            7'd13, 7'd14: v = 8'd4;
            7'd15: v = 8'd5;
            7'd16: v = 8'd6;
            7'd17: v = 8'd7;
            7'd18: v = 8'd8;
            7'd19: v = 8'd9;
            7'd20: v = 8'd10;
            7'd21: v = 8'd11;
            7'd22: v = 8'd12;
            7'd23: v = 8'd13;
            7'd24: v = 8'd14;
            7'd25: v = 8'd15;
            7'd26: v = 8'd17;
            7'd27: v = 8'd18;
            7'd28: v = 8'd19;
            7'd29: v = 8'd21;
            7'd30: v = 8'd22;
            7'd31: v = 8'd24;
            7'd32: v = 8'd26;
            7'd33: v = 8'd27;
            7'd34: v = 8'd29;
            7'd35: v = 8'd31;
            7'd36: v = 8'd33;
            7'd37: v = 8'd34;
            7'd38: v = 8'd36;
            7'd39: v = 8'd38;
            7'd40: v = 8'd40;
            7'd41: v = 8'd42;
            7'd42: v = 8'd44;
            7'd43: v = 8'd47;
            7'd44: v = 8'd49;
            7'd45: v = 8'd51;
            7'd46: v = 8'd53;
            7'd47: v = 8'd56;
            7'd48: v = 8'd58;
            7'd49: v = 8'd61;
            7'd50: v = 8'd63;
            7'd51: v = 8'd66;
            7'd52: v = 8'd68;
            7'd53: v = 8'd71;
            7'd54: v = 8'd74;
            7'd55: v = 8'd77;
            7'd56: v = 8'd79;
            7'd57: v = 8'd82;
            7'd58: v = 8'd85;
            7'd59: v = 8'd88;
            7'd60: v = 8'd91;
            7'd61: v = 8'd94;
            7'd62: v = 8'd98;
            7'd63: v = 8'd101;
            7'd64: v = 8'd104;
            7'd65: v = 8'd107;
            7'd66: v = 8'd111;
            7'd67: v = 8'd114;
            7'd68: v = 8'd117;
            7'd69: v = 8'd121;
            7'd70: v = 8'd124;
            7'd71: v = 8'd128;
            7'd72: v = 8'd132;
            7'd73: v = 8'd135;
            7'd74: v = 8'd139;
            7'd75: v = 8'd143;
            7'd76: v = 8'd147;
            7'd77: v = 8'd151;
            7'd78: v = 8'd155;
            7'd79: v = 8'd159;
            7'd80: v = 8'd163;
            7'd81: v = 8'd167;
            7'd82: v = 8'd171;
            7'd83: v = 8'd175;
            7'd84: v = 8'd179;
            7'd85: v = 8'd184;
            7'd86: v = 8'd188;
            7'd87: v = 8'd193;
            7'd88: v = 8'd197;
            7'd89: v = 8'd201;
            7'd90: v = 8'd206;
            7'd91: v = 8'd211;
            7'd92: v = 8'd215;
            7'd93: v = 8'd220;
            7'd94: v = 8'd225;
            7'd95: v = 8'd230;
            7'd96: v = 8'd235;
            7'd97: v = 8'd239;
            7'd98: v = 8'd244;
            7'd99: v = 8'd249;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    // ceil(2^21 / m); a zero multiplier acts as one
    function automatic logic [21:0] recip_of(input logic [4:0] m);
        logic [21:0] r;
        case (m)
            5'd2:  r = 22'd1048576;
            5'd3:  r = 22'd699051;
            5'd4:  r = 22'd524288;
            5'd5:  r = 22'd419431;
            5'd6:  r = 22'd349526;
            5'd7:  r = 22'd299594;
            5'd8:  r = 22'd262144;
            5'd9:  r = 22'd233017;
            5'd10: r = 22'd209716;
            5'd11: r = 22'd190651;
            5'd12: r = 22'd174763;
            5'd13: r = 22'd161320;
            5'd14: r = 22'd149797;
            5'd15: r = 22'd139811;
            5'd16: r = 22'd131072;
            5'd17: r = 22'd123362;
            5'd18: r = 22'd116509;
            5'd19: r = 22'd110377;
            5'd20: r = 22'd104858;
            5'd21: r = 22'd99865;
            5'd22: r = 22'd95326;
            5'd23: r = 22'd91181;
            5'd24: r = 22'd87382;
            5'd25: r = 22'd83887;
            5'd26: r = 22'd80660;
            5'd27: r = 22'd77673;
            5'd28: r = 22'd74899;
            5'd29: r = 22'd72316;
            5'd30: r = 22'd69906;
            5'd31: r = 22'd67651;
            default: r = 22'd2097152;
        endcase
        return r;
    endfunction

    // floor(65535 / m); a zero multiplier acts as one
    function automatic logic [15:0] sat_quot_of(input logic [4:0] m);
        logic [15:0] q;
        case (m)
            5'd2:  q = 16'd32767;
            5'd3:  q = 16'd21845;
            5'd4:  q = 16'd16383;
            5'd5:  q = 16'd13107;
            5'd6:  q = 16'd10922;
            5'd7:  q = 16'd9362;
            5'd8:  q = 16'd8191;
            5'd9:  q = 16'd7281;
            5'd10: q = 16'd6553;
            5'd11: q = 16'd5957;
            5'd12: q = 16'd5461;
            5'd13: q = 16'd5041;
            5'd14: q = 16'd4681;
            5'd15: q = 16'd4369;
            5'd16: q = 16'd4095;
            5'd17: q = 16'd3855;
            5'd18: q = 16'd3640;
            5'd19: q = 16'd3449;
            5'd20: q = 16'd3276;
            5'd21: q = 16'd3120;
            5'd22: q = 16'd2978;
            5'd23: q = 16'd2849;
            5'd24: q = 16'd2730;
            5'd25: q = 16'd2621;
            5'd26: q = 16'd2520;
            5'd27: q = 16'd2427;
            5'd28: q = 16'd2340;
            5'd29: q = 16'd2259;
            5'd30: q = 16'd2184;
            5'd31: q = 16'd2114;
            default: q = 16'd65535;
        endcase
        return q;
    endfunction

endpackage

FILE: design/lgfr_ifs.sv
// lgfr_ifs: valid/ready channel interfaces for command, result and config words.
// Depends on lgfr_pkg for the config port widths.
`timescale 1ns / 1ps

interface lgfr_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [6:0] percent;

    modport source (output valid, output op, output percent, input ready);
    modport sink   (input valid, input op, input percent, output ready);
endinterface

interface lgfr_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic       fading;

    modport source (output valid, output duty, output fading, input ready);
    modport sink   (input valid, input duty, input fading, output ready);
endinterface

interface lgfr_cfg_if
    import lgfr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: design/led_gamma_fade_ramp.sv
// led_gamma_fade_ramp: backlight fade generator with a square-law brightness map.
// Words pass from the command register through the step logic into the result register.
// Throughput: one command word per cycle while results drain; the step logic between
// the command register and the result register finishes each word in a single pass.
// Reset (rst_n low, asynchronous): duty 0, idle, fade_step 64, fade_multiplier 2.
`timescale 1ns / 1ps

module led_gamma_fade_ramp
    import lgfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lgfr_cfg_if.sink    cfg,
    lgfr_cmd_if.sink    cmd,
    lgfr_res_if.source  res
);

    cfg_t cfg_regs;

    // Configuration registers
    lgfr_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    // Fade datapath
    lgfr_fade_core u_fade_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res),
        .cfg   (cfg_regs)
    );

endmodule

FILE: design/lgfr_cfg_regs.sv
// lgfr_cfg_regs: fade step and multiplier registers behind the config channel.
// Depends on lgfr_pkg (cfg_t, register indexes, reciprocal tables) and lgfr_cfg_if.
`timescale 1ns / 1ps

module lgfr_cfg_regs
    import lgfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lgfr_cfg_if.sink    cfg,
    output cfg_t        regs
);

    cfg_t       cfg_reg;
    logic [4:0] mult_eff;

    // Accept every config word at once
    assign cfg.ready = 1'b1;

    // Map a zero multiplier to one before it is stored
    assign mult_eff = (cfg.data[4:0] == 5'd0) ? 5'd1 : cfg.data[4:0];

    // Hold registers, store derived divide constants on a multiplier write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fade_step <= FADE_STEP_RST;
            cfg_reg.mult      <= FADE_MULT_RST;
            cfg_reg.recip     <= recip_of(FADE_MULT_RST);
            cfg_reg.sat_quot  <= sat_quot_of(FADE_MULT_RST);
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                REG_FADE_STEP:
                begin
                    cfg_reg.fade_step <= cfg.data[11:0];
                end
                REG_FADE_MULT:
                begin
                    cfg_reg.mult     <= mult_eff;
                    cfg_reg.recip    <= recip_of(mult_eff);
                    cfg_reg.sat_quot <= sat_quot_of(mult_eff);
                end
                default:
                begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    assign regs = cfg_reg;

endmodule

FILE: design/lgfr_step_calc.sv
// lgfr_step_calc: next fade state for one command word (tick, set, off).
// Depends on lgfr_pkg (fade_state_t, cfg_t, command codes, brightness map).
`timescale 1ns / 1ps

module lgfr_step_calc
    import lgfr_pkg::*;
(
    input  fade_state_t cur,
    input  cfg_t        cfg,
    input  logic [1:0]  op,
    input  logic [6:0]  percent,
    output fade_state_t nxt
);

    logic [7:0]  tgt;
    logic [7:0]  duty_now;
    logic [7:0]  span;
    logic [7:0]  lo;
    logic [15:0] third_prod;
    logic [7:0]  third;
    fade_state_t start_st;
    fade_state_t adv_in;
    fade_state_t adv_out;
    logic [16:0] sum_up;
    logic        ovf;
    logic [15:0] acc_raw;
    logic [7:0]  d;
    logic [7:0]  d_clamp;
    logic [7:0]  d_final;
    logic        mul_hit;
    logic        div_hit;
    logic [20:0] prod;
    logic [15:0] prod_sat;
    logic [37:0] qprod;
    logic [15:0] quot;

    // Set up a new fade: target, direction, thirds of the distance
    always_comb
    begin
        tgt      = sq_map(percent);
        duty_now = cur.accum[15:8];
        if (duty_now < tgt)
        begin
            span = tgt - duty_now;
            lo   = duty_now;
        end
        else
        begin
            span = duty_now - tgt;
            lo   = tgt;
        end
        third_prod = 16'(span) * 16'(THIRD_RECIP);
        third      = {1'b0, third_prod[15:THIRD_SHIFT]};

        start_st          = cur;
        start_st.target   = tgt;
        start_st.down     = (duty_now > tgt);
        start_st.step     = {4'd0, cfg.fade_step};
        start_st.speedup  = lo + third;
        start_st.slowdown = lo + third + third;
        start_st.active   = 1'b1;
    end

    // A set command takes its first step in the same pass
    assign adv_in = (op == OP_SET) ? start_st : cur;

    // Scale the step up by the multiplier and back down by it
    assign prod     = 21'(adv_in.step) * 21'(cfg.mult);
    assign prod_sat = (prod[20:16] != 5'd0) ? 16'hFFFF : prod[15:0];
    assign qprod    = 38'(adv_in.step) * 38'(cfg.recip);
    assign quot     = qprod[RECIP_SHIFT+15:RECIP_SHIFT];

    // Advance the accumulator one step and clamp at the target
    always_comb
    begin
        sum_up = {1'b0, adv_in.accum} + {1'b0, adv_in.step};
        adv_out = adv_in;
        if (!adv_in.down)
        begin
            ovf     = sum_up[16];
            acc_raw = sum_up[15:0];
        end
        else
        begin
            ovf     = (adv_in.step > adv_in.accum);
            acc_raw = adv_in.accum - adv_in.step;
        end
        d = acc_raw[15:8];

        if (!adv_in.down)
        begin
            mul_hit = (d > adv_in.speedup);
            div_hit = (d > adv_in.slowdown);
            d_clamp = (d > adv_in.target) ? adv_in.target : d;
            if (mul_hit)
                adv_out.speedup = 8'hFF;
            if (div_hit)
                adv_out.slowdown = 8'hFF;
        end
        else
        begin
            mul_hit = (d < adv_in.slowdown);
            div_hit = (d < adv_in.speedup);
            d_clamp = (d < adv_in.target) ? adv_in.target : d;
            if (mul_hit)
                adv_out.slowdown = 8'h00;
            if (div_hit)
                adv_out.speedup = 8'h00;
        end

        // Crossing both marks at once multiplies, then divides the step back
        case ({mul_hit, div_hit})
            2'b10:   adv_out.step = prod_sat;
            2'b01:   adv_out.step = quot;
            2'b11:   adv_out.step = (prod[20:16] != 5'd0) ? cfg.sat_quot : adv_in.step;
            default: adv_out.step = adv_in.step;
        endcase

        // Snap to the target on a carry or borrow out of the accumulator
        d_final        = ovf ? adv_in.target : d_clamp;
        adv_out.accum  = {d_final, acc_raw[7:0]};
        adv_out.active = !(ovf || (d_final == adv_in.target));
    end

    // Pick the next state by command
    always_comb
    begin
        nxt = cur;
        case (op)
            OP_TICK:
            begin
                if (cur.active)
                    nxt = adv_out;
            end
            OP_SET:
            begin
                if (duty_now == tgt)
                begin
                    nxt.target = tgt;
                    nxt.active = 1'b0;
                end
                else
                begin
                    nxt = adv_out;
                end
            end
            OP_OFF:
            begin
                nxt.target      = 8'd0;
                nxt.accum[15:8] = 8'd0;
                nxt.active      = 1'b0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

FILE: design/lgfr_fade_core.sv
// lgfr_fade_core: command register, fade state, step logic and result register.
// Depends on lgfr_pkg, lgfr_cmd_if, lgfr_res_if and lgfr_step_calc.
`timescale 1ns / 1ps

module lgfr_fade_core
    import lgfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lgfr_cmd_if.sink    cmd,
    lgfr_res_if.source  res,
    input  cfg_t        cfg
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [1:0]  in_op_reg;
    logic [6:0]  in_pct_reg;
    fade_state_t st_reg;
    fade_state_t st_next;
    fade_state_t calc_state;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_duty_reg;
    logic        out_fading_reg;
    logic        fire;
    logic        cmd_take;

    // Process the held word whenever the result register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || fire;
    assign cmd_take = cmd.valid && cmd.ready;

    lgfr_step_calc u_step_calc (
        .cur     (st_reg),
        .cfg     (cfg),
        .op      (in_op_reg),
        .percent (in_pct_reg),
        .nxt     (calc_state)
    );

    // Advance occupancy of both registers and the fade state
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd_take)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;

        st_next = fire ? calc_state : st_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
        end
    end

    // Capture the command word
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            in_op_reg  <= cmd.op;
            in_pct_reg <= cmd.percent;
        end
    end

    // Register the result word
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_duty_reg   <= calc_state.accum[15:8];
            out_fading_reg <= calc_state.active;
        end
    end

    assign res.valid  = out_valid_reg;
    assign res.duty   = out_duty_reg;
    assign res.fading = out_fading_reg;

endmodule

FILE: design/lgfr_chk.sv
// lgfr_chk: port-level checks of the fade generator, bound to the top level.
// Depends on lgfr_pkg for the command codes.
`timescale 1ns / 1ps

module lgfr_chk
    import lgfr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic [1:0] cmd_op,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_duty,
    input logic       res_fading
);

    // Hold a stalled result word
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_duty) && $stable(res_fading))
        else $error("result word changed while stalled");

    // Stall commands only behind a stalled result
    a_cmd_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> res_valid && !res_ready)
        else $error("command channel stalled with result side free");

    // A new result word follows an accepted command through the command and result registers
    a_res_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_valid && cmd_ready, 2))
        else $error("result word without a command");

    // Drop duty and fading right after an off command
    a_off: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd_op == OP_OFF) ##1 (res_ready || !res_valid)
        |=> res_valid && res_duty == 8'd0 && !res_fading)
        else $error("off command did not clear duty");

endmodule

bind led_gamma_fade_ramp lgfr_chk u_lgfr_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .cmd_op     (cmd.op),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_duty   (res.duty),
    .res_fading (res.fading)
);
